@@ src/aesd_pkg.sv @@
// Shared constants and controller/datapath interface types for the archive entry decryptor.
package aesd_pkg;

    localparam logic [31:0] KEY_MAGIC  = 32'hA0F8EFE6;
    localparam logic [31:0] KEY_MIX    = 32'hFFFFCDEC;
    localparam logic [31:0] INNER_MUL  = 32'd69069;
    localparam logic [31:0] INNER_STEP = 32'd23023;
    localparam logic [31:0] OUTER_STEP = 32'd6339797;
    localparam logic [31:0] OUTER_SEED = 32'd101436752;

    localparam int unsigned HOLD_LEN  = 8;

    localparam logic CFG_OFFSET = 1'b0;
    localparam logic CFG_LENGTH = 1'b1;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic restart;
        logic live;
        logic header_end;
        logic magic_ok;
        logic rel_done;
        logic out_free;
    } aesd_sts_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic advance;
        logic head_store;
        logic key_load;
        logic rel_start;
        logic rel_step;
        logic body_emit;
    } aesd_cmd_t;

endpackage

@@ src/aesd_ctrl.sv @@
// Controller state machine for the archive entry decryptor.
module aesd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  aesd_pkg::aesd_sts_t   sts,
    output aesd_pkg::aesd_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_HEAD,
        ST_RELEASE,
        ST_BODY
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg != ST_RELEASE) && sts.out_free;
        cmd.advance = s_tvalid && s_tready && sts.live;
        case (state_reg)
            ST_HEAD:
            begin
                cmd.head_store = cmd.advance;
                if (cmd.advance && sts.header_end)
                begin
                    if (sts.magic_ok)
                    begin
                        cmd.key_load = 1'b1;
                        state_next   = ST_BODY;
                    end
                    else
                    begin
                        cmd.rel_start = 1'b1;
                        state_next    = ST_RELEASE;
                    end
                end
            end
            ST_RELEASE:
            begin
                cmd.rel_step = sts.out_free;
                if (sts.out_free && sts.rel_done)
                begin
                    state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                cmd.body_emit = cmd.advance;
            end
            default:
            begin
                state_next = ST_HEAD;
            end
        endcase
        if (sts.restart)
        begin
            state_next = ST_HEAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The held header is drained without taking new bytes.
    a_no_take_in_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELEASE) |-> !s_tready)
        else $error("input taken while releasing held header");

    a_key_to_body: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.key_load && !sts.restart) |=> (state_reg == ST_BODY))
        else $error("key load did not enter body state");

    a_release_entered: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rel_start && !sts.restart) |=> (state_reg == ST_RELEASE))
        else $error("header release did not start");

endmodule

@@ src/aesd_datapath.sv @@
// Datapath of the archive entry decryptor: keystreams, header hold and output register.
module aesd_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [7:0]            s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,
    input  aesd_pkg::aesd_cmd_t   cmd,
    output aesd_pkg::aesd_sts_t   sts
);

    logic [31:0] offset_reg, offset_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [63:0] hold_reg, hold_next;
    logic [31:0] ks_reg, ks_next;
    logic [31:0] inc_reg, inc_next;
    logic        keyed_reg, keyed_next;
    logic [31:0] keyed_end_reg, keyed_end_next;
    logic [2:0]  rel_idx_reg, rel_idx_next;
    logic [2:0]  rel_cnt_reg, rel_cnt_next;
    logic        rel_final_reg, rel_final_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_final_reg, out_final_next;
    logic        out_keyed_reg, out_keyed_next;

    logic [31:0] pos_inc;
    logic        last;
    logic [7:0]  outer_byte;
    logic [31:0] seed_src;
    logic [31:0] key;
    logic [31:0] ks_mix;
    logic [31:0] ks_step;
    logic        inner_on;

    assign pos_inc    = pos_reg + 32'd1;
    assign last       = (pos_inc == len_reg);
    assign outer_byte = s_tdata ^ acc_reg[23:16];
    assign seed_src   = (cfg_index == aesd_pkg::CFG_OFFSET) ? cfg_data : offset_reg;
    assign key        = {outer_byte, hold_reg[55:32]};
    assign ks_mix     = inc_reg + aesd_pkg::INNER_STEP * ks_reg;
    assign ks_step    = ks_mix + {ks_mix[30:0], 1'b0};
    assign inner_on   = keyed_reg && (pos_reg < keyed_end_reg);

    assign sts.restart    = cfg_we;
    assign sts.live       = (pos_reg < len_reg);
    assign sts.header_end = (pos_reg[2:0] == 3'd7) || last;
    assign sts.magic_ok   = (pos_reg[2:0] == 3'd7) && (hold_reg[31:0] == aesd_pkg::KEY_MAGIC);
    assign sts.rel_done   = (rel_idx_reg == rel_cnt_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_final_reg;
    assign m_tuser  = out_keyed_reg;

    always_comb
    begin
        offset_next    = offset_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        hold_next      = hold_reg;
        ks_next        = ks_reg;
        inc_next       = inc_reg;
        keyed_next     = keyed_reg;
        rel_idx_next   = rel_idx_reg;
        rel_cnt_next   = rel_cnt_reg;
        rel_final_next = rel_final_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_final_next = out_final_reg;
        out_keyed_next = out_keyed_reg;
        // Word-aligned end of the inner layer; bytes past it stay clear.
        keyed_end_next = ((len_reg - 32'd8) & ~32'd3) + 32'd8;

        if (cmd.advance)
        begin
            pos_next = pos_inc;
            acc_next = acc_reg + aesd_pkg::OUTER_STEP;
        end

        if (cmd.head_store)
        begin
            hold_next[{pos_reg[2:0], 3'b000} +: 8] = outer_byte;
        end

        if (cmd.key_load)
        begin
            keyed_next = 1'b1;
            ks_next    = key | ((key ^ aesd_pkg::KEY_MIX) << 16);
            inc_next   = aesd_pkg::INNER_MUL * key;
        end

        if (cmd.rel_start)
        begin
            rel_idx_next   = 3'd0;
            rel_cnt_next   = pos_reg[2:0];
            rel_final_next = last;
        end

        if (cmd.rel_step)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = hold_reg[{rel_idx_reg, 3'b000} +: 8];
            out_final_next = rel_final_reg && (rel_idx_reg == rel_cnt_reg);
            out_keyed_next = 1'b0;
            rel_idx_next   = rel_idx_reg + 3'd1;
        end

        if (cmd.body_emit)
        begin
            out_valid_next = 1'b1;
            out_final_next = last;
            out_keyed_next = keyed_reg;
            if (inner_on)
            begin
                out_byte_next = outer_byte ^ ks_reg[{pos_reg[1:0], 3'b000} +: 8];
                if (pos_reg[1:0] == 2'd3)
                begin
                    ks_next = ks_step;
                end
            end
            else
            begin
                out_byte_next = outer_byte;
            end
        end

        if (cfg_we)
        begin
            if (cfg_index == aesd_pkg::CFG_OFFSET)
            begin
                offset_next = cfg_data;
            end
            else
            begin
                len_next = cfg_data;
            end
            pos_next   = '0;
            acc_next   = aesd_pkg::OUTER_SEED * seed_src;
            hold_next  = '0;
            ks_next    = '0;
            inc_next   = '0;
            keyed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            len_reg       <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            hold_reg      <= '0;
            ks_reg        <= '0;
            inc_reg       <= '0;
            keyed_reg     <= 1'b0;
            keyed_end_reg <= '0;
            rel_idx_reg   <= '0;
            rel_cnt_reg   <= '0;
            rel_final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_final_reg <= 1'b0;
            out_keyed_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            hold_reg      <= hold_next;
            ks_reg        <= ks_next;
            inc_reg       <= inc_next;
            keyed_reg     <= keyed_next;
            keyed_end_reg <= keyed_end_next;
            rel_idx_reg   <= rel_idx_next;
            rel_cnt_reg   <= rel_cnt_next;
            rel_final_reg <= rel_final_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_final_reg <= out_final_next;
            out_keyed_reg <= out_keyed_next;
        end
    end

    a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rel_step || cmd.body_emit) |=> out_valid_reg)
        else $error("emitted byte not registered");

    a_released_bytes_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rel_step |=> !out_keyed_reg)
        else $error("released header byte flagged keyed");

    a_position_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && !cfg_we) |=> (pos_reg <= len_reg))
        else $error("byte position ran past entry length");

endmodule

@@ src/archive_entry_stream_decryptor.sv @@
// Top level of the archive entry stream decryptor.
//
// Usage: write entry_block_offset (index 0) and entry_length (index 1) on the
// configuration port while the block is idle; either write restarts the entry.
// Ciphertext bytes then enter on the slave stream, one per transaction, in
// file order, and plaintext payload bytes leave on the master stream with
// tlast marking the final payload byte and tuser set on keyed entries.
// A body byte enters the output register in the cycle after its transaction.
// The first eight bytes are held; for an unkeyed entry (or one shorter than
// eight bytes) they are then released one at a time from the hold register
// while the input stalls. A keyed header yields no output. After the header,
// throughput is one byte per cycle while the receiver keeps taking bytes,
// through the single output register; the inner keystream steps once per word.
// Bytes offered beyond entry_length are taken and discarded.
// Reset clears all state, both registers and the output register; no memory
// needs clearing. When the receiver stalls, the output register holds its
// byte and the input is not taken until that byte has gone.
module archive_entry_stream_decryptor (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // Ciphertext stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] cipher_byte
    // Plaintext stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] plain_byte
    output logic        m_tlast,   // final_byte
    output logic        m_tuser    // [0] keyed_layer
);

    aesd_pkg::aesd_sts_t sts;
    aesd_pkg::aesd_cmd_t cmd;

    // The controller sequences header capture, release and body bytes.
    aesd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds both keystreams, the header and the output register.
    aesd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the archive entry stream decryptor.
module testbench;

    localparam int unsigned HALF_PERIOD   = 6;
    localparam int unsigned DRAIN_CYCLES  = 12;    // margin after the last result for work that produces no output
    localparam int unsigned QUIET_LIMIT   = 4000;  // cycles with no transaction on either side
    localparam int unsigned HOLDOFF_LEN   = 80;
    localparam int unsigned RANDOM_BYTES  = 300;

    // How the first eight plaintext bytes of an entry are built.
    typedef enum int {HDR_CLEAR, HDR_KEYED, HDR_BROKEN} header_kind_t;

    // One plaintext transaction as the master stream should carry it.
    typedef struct packed {
        logic [7:0] plain;
        logic       fin;
        logic       keyed;
    } plain_byte_t;

    // Tracks the decryptor state and holds the plaintext bytes still due.
    class plaintext_scoreboard;
        logic [31:0]  block_offset;
        logic [31:0]  entry_bytes;
        logic [31:0]  bytes_taken;
        logic [31:0]  outer_sum;
        logic [63:0]  header_bytes;
        logic [31:0]  inner_word;
        logic [31:0]  inner_add;
        logic         keyed;
        plain_byte_t  plain_due[$];
        int unsigned  mismatches;
        int unsigned  results_checked;

        function new();
            block_offset    = '0;
            entry_bytes     = '0;
            mismatches      = 0;
            results_checked = 0;
            restart();
        endfunction

        function void restart();
            bytes_taken  = '0;
            outer_sum    = aesd_pkg::OUTER_SEED * block_offset;
            header_bytes = '0;
            inner_word   = '0;
            inner_add    = '0;
            keyed        = 1'b0;
        endfunction

        function void load_register(logic index, logic [31:0] value);
            if (index == aesd_pkg::CFG_OFFSET)
                block_offset = value;
            else
                entry_bytes = value;
            restart();
        endfunction

        function int unsigned pending();
            return plain_due.size();
        endfunction

        function void push(logic [7:0] plain, logic fin, logic keyed_flag);
            plain_byte_t item;
            item.plain = plain;
            item.fin   = fin;
            item.keyed = keyed_flag;
            plain_due.push_back(item);
        endfunction

        // Advances the model by one accepted ciphertext byte.
        function void take_cipher_byte(logic [7:0] cipher);
            logic [31:0] pos;
            logic [7:0]  value;
            logic        last;
            logic [31:0] key;
            logic [31:0] word_bytes;
            logic [31:0] body_pos;
            int unsigned lane;
            pos = bytes_taken;
            // Bytes past the end of the entry leave no trace.
            if (pos >= entry_bytes)
                return;
            value       = cipher ^ outer_sum[23:16];
            outer_sum   = outer_sum + aesd_pkg::OUTER_STEP;
            bytes_taken = pos + 32'd1;
            last        = (bytes_taken == entry_bytes);
            if (pos < aesd_pkg::HOLD_LEN) begin
                header_bytes[8*pos +: 8] = value;
                if (pos == aesd_pkg::HOLD_LEN - 1 &&
                    header_bytes[31:0] == aesd_pkg::KEY_MAGIC) begin
                    key        = header_bytes[63:32];
                    keyed      = 1'b1;
                    inner_word = key | ((key ^ aesd_pkg::KEY_MIX) << 16);
                    inner_add  = aesd_pkg::INNER_MUL * key;
                    return;
                end
                // Held bytes leave together once the header is complete or the entry ends.
                if (pos == aesd_pkg::HOLD_LEN - 1 || last) begin
                    for (int unsigned k = 0; k <= pos; k++)
                        push(header_bytes[8*k +: 8], last && k == pos, 1'b0);
                end
                return;
            end
            if (keyed) begin
                body_pos   = pos - aesd_pkg::HOLD_LEN;
                word_bytes = (entry_bytes - aesd_pkg::HOLD_LEN) & ~32'd3;
                // Only whole words are masked; a partial final word passes in the clear.
                if (body_pos < word_bytes) begin
                    lane  = 32'(body_pos[1:0]);
                    value = value ^ inner_word[8*lane +: 8];
                    if (lane == 3)
                        inner_word = 32'd3 * (inner_add + aesd_pkg::INNER_STEP * inner_word);
                end
            end
            push(value, last, keyed);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_plain_byte(logic [7:0] plain, logic fin, logic keyed_flag);
            plain_byte_t due;
            if (plain_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", plain));
                return;
            end
            due = plain_due.pop_front();
            results_checked++;
            if (plain !== due.plain)
                report_mismatch($sformatf("plain_byte %02h, expected %02h", plain, due.plain));
            if (fin !== due.fin)
                report_mismatch($sformatf("final_byte %0b, expected %0b", fin, due.fin));
            if (keyed_flag !== due.keyed)
                report_mismatch($sformatf("keyed_layer %0b, expected %0b",
                                          keyed_flag, due.keyed));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    plaintext_scoreboard sb = new();

    // When set, neither side inserts random idle cycles.
    bit          steady = 1'b0;
    // Each increment asks the receiver for one long hold-off.
    int unsigned stalls_requested = 0;
    int unsigned payload_offered  = 0;
    int unsigned entries_by_kind[3] = '{0, 0, 0};

    archive_entry_stream_decryptor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // Both monitors sample at the rising edge; all stimulus moves at the falling
    // edge, so the values seen here are settled.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.take_cipher_byte(s_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_plain_byte(m_tdata, m_tlast, m_tuser);
    end

    // Receiver: mostly ready, idles about one cycle in ten, and on request holds
    // off for a long stretch so that the output register fills and the input stalls.
    initial
    begin : receiver
        int unsigned holdoff;
        int unsigned served;
        holdoff  = 0;
        served   = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (served != stalls_requested)
            begin
                served  = stalls_requested;
                holdoff = HOLDOFF_LEN;
            end
            if (holdoff != 0)
            begin
                holdoff--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || $urandom_range(99) >= 10;
        end
    end

    // Watchdog: the run is stuck if no transaction happens on either side for too long.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("archive_entry_stream_decryptor test failed");
        $finish;
    end

    // Outer keystream byte for ciphertext byte pos of an entry at the given offset.
    function automatic logic [7:0] outer_mask(logic [31:0] offset, logic [31:0] pos);
        logic [31:0] sum;
        sum = aesd_pkg::OUTER_SEED * offset + aesd_pkg::OUTER_STEP * pos;
        return sum[23:16];
    endfunction

    // Writes both registers back to back; each write restarts the entry.
    // Called at a falling edge while the block is idle.
    task automatic configure_entry(input logic [31:0] offset, input logic [31:0] length);
        cfg_we    <= 1'b1;
        cfg_index <= aesd_pkg::CFG_OFFSET;
        cfg_data  <= offset;
        @(posedge clk);
        sb.load_register(aesd_pkg::CFG_OFFSET, offset);
        @(negedge clk);
        cfg_index <= aesd_pkg::CFG_LENGTH;
        cfg_data  <= length;
        @(posedge clk);
        sb.load_register(aesd_pkg::CFG_LENGTH, length);
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= $urandom;
    endtask

    // Offers one ciphertext byte and returns at the falling edge after its transaction.
    // tvalid stays high on return so that back-to-back bytes leave no gap.
    task automatic send_cipher_byte(input logic [7:0] value);
        while (!steady && $urandom_range(99) < 10)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every predicted plaintext byte has been seen, then lets the
    // block finish any work that produces no output (keyed header, dropped bytes).
    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Configures one entry and streams count bytes of it. The plaintext header is
    // chosen first and then encrypted with the outer layer, so that keyed headers
    // really decode to the key magic. count may exceed length to send dropped bytes.
    task automatic run_entry(input logic [31:0] offset, input logic [31:0] length,
                             input int unsigned count, input header_kind_t kind,
                             input bit holdoff_midway);
        logic [31:0] magic_word;
        logic [31:0] key;
        logic [7:0]  plain;
        magic_word = aesd_pkg::KEY_MAGIC;
        if (kind == HDR_BROKEN)
            magic_word = magic_word ^ (32'd1 << $urandom_range(31));
        key = $urandom;
        entries_by_kind[kind]++;
        configure_entry(offset, length);
        for (int unsigned p = 0; p < count; p++)
        begin
            if (kind != HDR_CLEAR && p < 4)
                plain = magic_word[8*p +: 8];
            else if (kind != HDR_CLEAR && p < aesd_pkg::HOLD_LEN)
                plain = key[8*(p-4) +: 8];
            else
                plain = $urandom;
            if (holdoff_midway && p == 12)
                stalls_requested++;
            if (p < length)
                payload_offered++;
            send_cipher_byte(plain ^ outer_mask(offset, p));
        end
        s_tvalid <= 1'b0;
        // The sender pauses here until every result of the entry has arrived.
        wait_for_drain();
    endtask

    initial
    begin : stimulus
        logic [31:0]  offset;
        logic [31:0]  length;
        int unsigned  count;
        int unsigned  pick;
        int unsigned  directed_bytes;
        int unsigned  entry;
        header_kind_t kind;
        bit           holdoff;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = aesd_pkg::CFG_OFFSET;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed entries: an empty entry whose bytes are all dropped, a short
        // entry at the top offset with one byte past its end, a keyed entry that
        // is nothing but its header, and a keyed entry with one masked word and
        // a clear tail byte.
        run_entry(32'h0000_0000, 32'd0, 2, HDR_CLEAR, 1'b0);
        run_entry(32'hFFFF_FFFF, 32'd3, 4, HDR_CLEAR, 1'b0);
        run_entry(32'h0000_0000, 32'd8, 8, HDR_KEYED, 1'b0);
        run_entry(32'h0001_2345, 32'd13, 13, HDR_KEYED, 1'b0);
        directed_bytes = payload_offered;

        // Random entries: mostly well-formed keyed entries of modest length,
        // with clear and broken headers, short entries, entries far longer
        // than what is sent, and bytes past the end mixed in.
        entry = 0;
        while (payload_offered - directed_bytes < RANDOM_BYTES)
        begin
            steady = (entry >= 8 && entry < 16);
            case ($urandom_range(9))
                0:       offset = 32'h0000_0000;
                1:       offset = 32'hFFFF_FFFF;
                default: offset = $urandom;
            endcase
            holdoff = (entry == 3 || entry == 20);
            pick    = $urandom_range(99);
            if (holdoff)
            begin
                length = 32'd40;
                count  = 40;
            end
            else if (pick < 8)
            begin
                length = $urandom_range(7);
                count  = length;
            end
            else if (pick < 14)
            begin
                length = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
                count  = $urandom_range(24, 8);
            end
            else
            begin
                length = $urandom_range(40, 8);
                count  = length;
            end
            if (count == length && $urandom_range(4) == 0)
                count += $urandom_range(3, 1);
            pick = $urandom_range(99);
            if (holdoff || pick < 55)
                kind = HDR_KEYED;
            else if (pick < 65)
                kind = HDR_BROKEN;
            else
                kind = HDR_CLEAR;
            run_entry(offset, length, count, kind, holdoff);
            entry++;
        end
        steady = 1'b0;
        wait_for_drain();

        $display("Ran %0d entries: %0d keyed, %0d with a corrupted magic, %0d clear.",
                 entry + 4, entries_by_kind[HDR_KEYED], entries_by_kind[HDR_BROKEN],
                 entries_by_kind[HDR_CLEAR]);
        $display("Offered %0d payload bytes, checked %0d plaintext bytes, %0d long hold-offs.",
                 payload_offered, sb.results_checked, stalls_requested);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("archive_entry_stream_decryptor test passed");
        else
            $display("archive_entry_stream_decryptor test failed");
        $finish;
    end

endmodule
